### design/ppu_pkg.sv
// Shared types, constants and helpers of the particle pool update block.
`default_nettype none
package ppu_pkg;

	localparam int MAX_PARTICLES = 32;
	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	typedef enum logic [1:0] {
		OP_SPAWN = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_e;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [23:0]        life;
		logic [23:0]        max_life;
		logic [15:0]        size_start;
		logic [15:0]        size_final;
		logic [23:0]        color;
		logic signed [31:0] gravity;
		logic               additive;
	} rec_t;

	typedef struct packed {
		logic signed [31:0] rect_x;
		logic signed [31:0] rect_y;
		logic [15:0]        rect_size;
		logic [31:0]        argb_color;
		logic               sprite_additive;
		logic               last_sprite;
	} sprite_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_SPAWN_LOAD,
		DP_SCAN_NEXT,
		DP_SPAWN_WRITE,
		DP_CLEAR,
		DP_TICK_LOAD,
		DP_IDX_NEXT,
		DP_KILL,
		DP_EVAL,
		DP_MX,
		DP_MY,
		DP_MS,
		DP_MF,
		DP_LA,
		DP_EMIT,
		DP_FLUSH
	} dp_op_e;

	typedef struct packed {
		logic alive_cur;
		logic scan_last;
		logic idx_last;
		logic dies;
		logic div_busy;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_CHK,
		S_EVAL,
		S_MX,
		S_MY,
		S_MS,
		S_MF,
		S_DS,
		S_DA,
		S_EMIT,
		S_FLUSH
	} state_e;

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		logic signed [41:0] hi;
		logic signed [41:0] lo;
		hi = 42'sd2147483647;
		lo = -42'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

### design/ppu_if.sv
// Valid/ready channel interfaces for input items and output sprites.
`default_nettype none
interface ppu_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [23:0]        lifetime;
	logic [23:0]        time_step;
	logic [15:0]        size_start;
	logic [15:0]        size_final;
	logic [23:0]        rgb_color;
	logic signed [31:0] gravity_y;
	logic               blend_add;

	modport source (output valid, operation, pos_x, pos_y, vel_x, vel_y, lifetime,
		time_step, size_start, size_final, rgb_color, gravity_y, blend_add, input ready);
	modport sink (input valid, operation, pos_x, pos_y, vel_x, vel_y, lifetime,
		time_step, size_start, size_final, rgb_color, gravity_y, blend_add, output ready);
endinterface

interface ppu_sprite_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rect_x;
	logic signed [31:0] rect_y;
	logic [15:0]        rect_size;
	logic [31:0]        argb_color;
	logic               sprite_additive;
	logic               last_sprite;

	modport source (output valid, rect_x, rect_y, rect_size, argb_color, sprite_additive,
		last_sprite, input ready);
	modport sink (input valid, rect_x, rect_y, rect_size, argb_color, sprite_additive,
		last_sprite, output ready);
endinterface
`default_nettype wire

### design/particle_pool_update.sv
// Top level of the particle pool update block.
// A clear is done in the idle state; a spawn examines slots in turn from the next-free pointer
// until one is free or all are seen. A tick walks every slot, skips a free one, frees a dying
// particle and updates a survivor by the shared multiplier and the one-bit-per-cycle divider
// that forms the size (16 steps) and the alpha (8 steps), then may wait on the output port.
// Each sprite beat is held back until the next survivor is known, so that the last beat of a
// tick carries last_sprite. A new item is taken only once the previous one has finished.
`default_nettype none
module particle_pool_update (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ppu_item_if.sink      item,
	ppu_sprite_if.source  sprite
);

	ppu_pkg::dp_op_e     dp_op;
	ppu_pkg::dp_status_t status;
	ppu_pkg::rec_t       spawn_rec;
	ppu_pkg::sprite_t    spr;
	logic                spr_valid;

	always_comb begin
		spawn_rec.pos_x      = item.pos_x;
		spawn_rec.pos_y      = item.pos_y;
		spawn_rec.vel_x      = item.vel_x;
		spawn_rec.vel_y      = item.vel_y;
		spawn_rec.life       = item.lifetime;
		spawn_rec.max_life   = item.lifetime;
		spawn_rec.size_start = item.size_start;
		spawn_rec.size_final = item.size_final;
		spawn_rec.color      = item.rgb_color;
		spawn_rec.gravity    = item.gravity_y;
		spawn_rec.additive   = item.blend_add;
	end

	ppu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.operation  (item.operation),
		.item_ready (item.ready),
		.status     (status),
		.dp_op      (dp_op)
	);

	ppu_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_op        (dp_op),
		.spawn_rec    (spawn_rec),
		.time_step    (item.time_step),
		.status       (status),
		.sprite       (spr),
		.sprite_valid (spr_valid),
		.sprite_ready (sprite.ready)
	);

	assign sprite.valid           = spr_valid;
	assign sprite.rect_x          = spr.rect_x;
	assign sprite.rect_y          = spr.rect_y;
	assign sprite.rect_size       = spr.rect_size;
	assign sprite.argb_color      = spr.argb_color;
	assign sprite.sprite_additive = spr.sprite_additive;
	assign sprite.last_sprite     = spr.last_sprite;

endmodule
`default_nettype wire

### design/ppu_dpath.sv
// Datapath: slot memory, live flags, multiplier, divider and output stage.
`default_nettype none
module ppu_dpath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ppu_pkg::dp_op_e     dp_op,
	input  wire ppu_pkg::rec_t       spawn_rec,
	input  wire logic [23:0]         time_step,
	output ppu_pkg::dp_status_t      status,
	output ppu_pkg::sprite_t         sprite,
	output logic                     sprite_valid,
	input  wire logic                sprite_ready
);

	localparam int N = ppu_pkg::MAX_PARTICLES;
	localparam int W = ppu_pkg::IDX_W;

	ppu_pkg::rec_t mem [N];
	ppu_pkg::rec_t rd_q;
	ppu_pkg::rec_t spawn_q;
	ppu_pkg::rec_t wdata;
	ppu_pkg::sprite_t pend_q;
	ppu_pkg::sprite_t out_q;
	ppu_pkg::sprite_t cur;

	logic [N-1:0]       alive_q;
	logic [W-1:0]       next_free_q;
	logic [W-1:0]       idx_q;
	logic [W-1:0]       cnt_q;
	logic [W-1:0]       idx_next;
	logic [W-1:0]       waddr;
	logic               wen;
	logic [23:0]        dt_q;
	logic signed [56:0] p_q;
	logic signed [31:0] mul_a;
	logic signed [31:0] vy_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic [23:0]        life_q;
	logic [39:0]        sa_q;
	logic [39:0]        size_num;
	logic [31:0]        alpha_num;
	logic [23:0]        rem_q;
	logic [15:0]        sh_q;
	logic [4:0]         dcnt_q;
	logic [15:0]        size_q;
	logic [24:0]        trial;
	logic               ge;
	logic               pend_valid_q;
	logic               out_valid_q;
	logic               out_free;
	logic signed [41:0] scaled;

	assign idx_next = (idx_q == W'(N - 1)) ? '0 : idx_q + 1'b1;
	assign out_free = !out_valid_q || sprite_ready;
	assign scaled = {p_q[56], p_q[56:16]};

	assign status.alive_cur  = alive_q[idx_q];
	assign status.scan_last  = (cnt_q == W'(N - 1));
	assign status.idx_last   = (idx_q == W'(N - 1));
	assign status.dies       = (rd_q.life <= dt_q);
	assign status.div_busy   = (dcnt_q != 5'd0);
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	assign sprite       = out_q;
	assign sprite_valid = out_valid_q;

	always_comb begin
		unique case (dp_op)
			ppu_pkg::DP_EVAL: mul_a = rd_q.gravity;
			ppu_pkg::DP_MX:   mul_a = rd_q.vel_x;
			default:          mul_a = vy_q;
		endcase
	end

	assign size_num  = sa_q + 40'(rd_q.size_final * (rd_q.max_life - life_q));
	assign alpha_num = {life_q, 8'd0} - {8'd0, life_q};
	assign trial     = {rem_q, sh_q[15]};
	assign ge        = (trial >= {1'b0, rd_q.max_life});

	always_comb begin
		cur.rect_x = ppu_pkg::sat32({{10{px_q[31]}}, px_q} - {19'd0, size_q, 7'd0});
		cur.rect_y = ppu_pkg::sat32({{10{py_q[31]}}, py_q} - {19'd0, size_q, 7'd0});
		cur.rect_size       = size_q;
		cur.argb_color      = {sh_q[7:0], rd_q.color};
		cur.sprite_additive = rd_q.additive;
		cur.last_sprite     = 1'b0;
	end

	always_comb begin
		wen   = 1'b0;
		waddr = idx_q;
		wdata = spawn_q;
		if (dp_op == ppu_pkg::DP_SPAWN_WRITE) begin
			wen   = 1'b1;
			waddr = alive_q[idx_q] ? next_free_q : idx_q;
		end else if (dp_op == ppu_pkg::DP_EMIT) begin
			wen         = 1'b1;
			wdata       = rd_q;
			wdata.pos_x = px_q;
			wdata.pos_y = py_q;
			wdata.vel_y = vy_q;
			wdata.life  = life_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q      <= '0;
			next_free_q  <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			dcnt_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && sprite_ready) begin
				out_valid_q <= 1'b0;
			end
			if (dcnt_q != 5'd0) begin
				dcnt_q <= dcnt_q - 5'd1;
			end
			unique case (dp_op)
				ppu_pkg::DP_SPAWN_LOAD: begin
					idx_q <= next_free_q;
					cnt_q <= '0;
				end
				ppu_pkg::DP_SCAN_NEXT: begin
					idx_q <= idx_next;
					cnt_q <= cnt_q + 1'b1;
				end
				ppu_pkg::DP_SPAWN_WRITE: begin
					alive_q[waddr] <= 1'b1;
					next_free_q    <= (waddr == W'(N - 1)) ? '0 : waddr + 1'b1;
				end
				ppu_pkg::DP_CLEAR: begin
					alive_q     <= '0;
					next_free_q <= '0;
				end
				ppu_pkg::DP_TICK_LOAD: idx_q <= '0;
				ppu_pkg::DP_IDX_NEXT:  idx_q <= idx_next;
				ppu_pkg::DP_KILL: begin
					alive_q[idx_q] <= 1'b0;
					idx_q          <= idx_next;
				end
				ppu_pkg::DP_MF: dcnt_q <= 5'd16;
				ppu_pkg::DP_LA: dcnt_q <= 5'd8;
				ppu_pkg::DP_EMIT: begin
					idx_q        <= idx_next;
					pend_valid_q <= 1'b1;
					if (pend_valid_q) begin
						out_valid_q <= 1'b1;
					end
				end
				ppu_pkg::DP_FLUSH: begin
					pend_valid_q <= 1'b0;
					out_valid_q  <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dcnt_q != 5'd0) begin
			rem_q <= ge ? 24'(trial - {1'b0, rd_q.max_life}) : trial[23:0];
			sh_q  <= {sh_q[14:0], ge};
		end
		unique case (dp_op)
			ppu_pkg::DP_SPAWN_LOAD: spawn_q <= spawn_rec;
			ppu_pkg::DP_TICK_LOAD:  dt_q <= time_step;
			ppu_pkg::DP_EVAL: begin
				life_q <= rd_q.life - dt_q;
				p_q    <= mul_a * $signed({1'b0, dt_q});
			end
			ppu_pkg::DP_MX: begin
				vy_q <= ppu_pkg::sat32({{10{rd_q.vel_y[31]}}, rd_q.vel_y} + scaled);
				p_q  <= mul_a * $signed({1'b0, dt_q});
			end
			ppu_pkg::DP_MY: begin
				px_q <= ppu_pkg::sat32({{10{rd_q.pos_x[31]}}, rd_q.pos_x} + scaled);
				p_q  <= mul_a * $signed({1'b0, dt_q});
			end
			ppu_pkg::DP_MS: begin
				py_q <= ppu_pkg::sat32({{10{rd_q.pos_y[31]}}, rd_q.pos_y} + scaled);
				sa_q <= 40'(rd_q.size_start * life_q);
			end
			ppu_pkg::DP_MF: begin
				rem_q <= size_num[39:16];
				sh_q  <= size_num[15:0];
			end
			ppu_pkg::DP_LA: begin
				size_q <= sh_q;
				rem_q  <= alpha_num[31:8];
				sh_q   <= {alpha_num[7:0], 8'd0};
			end
			ppu_pkg::DP_EMIT: begin
				pend_q <= cur;
				if (pend_valid_q) begin
					out_q <= pend_q;
				end
			end
			ppu_pkg::DP_FLUSH: begin
				out_q             <= pend_q;
				out_q.last_sprite <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### design/ppu_ctrl.sv
// Controller state machine sequencing spawn, tick and clear through the datapath.
`default_nettype none
module ppu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire logic [1:0]          operation,
	output logic                     item_ready,
	input  wire ppu_pkg::dp_status_t status,
	output ppu_pkg::dp_op_e          dp_op
);

	ppu_pkg::state_e state_q;
	ppu_pkg::state_e state_next;

	assign item_ready = (state_q == ppu_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ppu_pkg::S_IDLE: begin
				if (item_valid) begin
					case (ppu_pkg::op_e'(operation))
						ppu_pkg::OP_SPAWN: state_next = ppu_pkg::S_SCAN;
						ppu_pkg::OP_TICK:  state_next = ppu_pkg::S_CHK;
						default:           state_next = ppu_pkg::S_IDLE;
					endcase
				end
			end
			ppu_pkg::S_SCAN: begin
				if (!status.alive_cur || status.scan_last) begin
					state_next = ppu_pkg::S_IDLE;
				end
			end
			ppu_pkg::S_CHK: begin
				if (status.alive_cur) begin
					state_next = ppu_pkg::S_EVAL;
				end else if (status.idx_last) begin
					state_next = ppu_pkg::S_FLUSH;
				end
			end
			ppu_pkg::S_EVAL: begin
				if (!status.dies) begin
					state_next = ppu_pkg::S_MX;
				end else if (status.idx_last) begin
					state_next = ppu_pkg::S_FLUSH;
				end else begin
					state_next = ppu_pkg::S_CHK;
				end
			end
			ppu_pkg::S_MX: state_next = ppu_pkg::S_MY;
			ppu_pkg::S_MY: state_next = ppu_pkg::S_MS;
			ppu_pkg::S_MS: state_next = ppu_pkg::S_MF;
			ppu_pkg::S_MF: state_next = ppu_pkg::S_DS;
			ppu_pkg::S_DS: begin
				if (!status.div_busy) begin
					state_next = ppu_pkg::S_DA;
				end
			end
			ppu_pkg::S_DA: begin
				if (!status.div_busy) begin
					state_next = ppu_pkg::S_EMIT;
				end
			end
			ppu_pkg::S_EMIT: begin
				if (!status.pend_valid || status.out_free) begin
					state_next = status.idx_last ? ppu_pkg::S_FLUSH : ppu_pkg::S_CHK;
				end
			end
			ppu_pkg::S_FLUSH: begin
				if (!status.pend_valid || status.out_free) begin
					state_next = ppu_pkg::S_IDLE;
				end
			end
			default: state_next = ppu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		dp_op = ppu_pkg::DP_NOP;
		unique case (state_q)
			ppu_pkg::S_IDLE: begin
				if (item_valid) begin
					case (ppu_pkg::op_e'(operation))
						ppu_pkg::OP_SPAWN: dp_op = ppu_pkg::DP_SPAWN_LOAD;
						ppu_pkg::OP_TICK:  dp_op = ppu_pkg::DP_TICK_LOAD;
						ppu_pkg::OP_CLEAR: dp_op = ppu_pkg::DP_CLEAR;
						default:           dp_op = ppu_pkg::DP_NOP;
					endcase
				end
			end
			ppu_pkg::S_SCAN: begin
				if (!status.alive_cur || status.scan_last) begin
					dp_op = ppu_pkg::DP_SPAWN_WRITE;
				end else begin
					dp_op = ppu_pkg::DP_SCAN_NEXT;
				end
			end
			ppu_pkg::S_CHK: begin
				if (!status.alive_cur) begin
					dp_op = ppu_pkg::DP_IDX_NEXT;
				end
			end
			ppu_pkg::S_EVAL: dp_op = status.dies ? ppu_pkg::DP_KILL : ppu_pkg::DP_EVAL;
			ppu_pkg::S_MX:   dp_op = ppu_pkg::DP_MX;
			ppu_pkg::S_MY:   dp_op = ppu_pkg::DP_MY;
			ppu_pkg::S_MS:   dp_op = ppu_pkg::DP_MS;
			ppu_pkg::S_MF:   dp_op = ppu_pkg::DP_MF;
			ppu_pkg::S_DS: begin
				if (!status.div_busy) begin
					dp_op = ppu_pkg::DP_LA;
				end
			end
			ppu_pkg::S_DA: dp_op = ppu_pkg::DP_NOP;
			ppu_pkg::S_EMIT: begin
				if (!status.pend_valid || status.out_free) begin
					dp_op = ppu_pkg::DP_EMIT;
				end
			end
			ppu_pkg::S_FLUSH: begin
				if (status.pend_valid && status.out_free) begin
					dp_op = ppu_pkg::DP_FLUSH;
				end
			end
			default: dp_op = ppu_pkg::DP_NOP;
		endcase
	end

endmodule
`default_nettype wire

### design/ppu_checker.sv
// Port-level checker for the particle pool update block, bound to the top level.
`default_nettype none
module ppu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire logic [1:0] item_operation,
	input wire logic sprite_valid,
	input wire logic sprite_ready
);

	a_sprite_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sprite_valid && !sprite_ready |=> sprite_valid)
		else $error("sprite beat dropped before it was taken");

	a_spawn_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_operation == ppu_pkg::OP_SPAWN |=> !item_ready)
		else $error("spawn did not occupy the block");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_operation == ppu_pkg::OP_CLEAR |=> item_ready)
		else $error("clear did not finish in one cycle");

	a_sprite_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sprite_valid) |-> $past(!item_ready))
		else $error("sprite beat appeared while the block was idle");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_operation (item.operation),
	.sprite_valid   (sprite.valid),
	.sprite_ready   (sprite.ready)
);
`default_nettype wire
